// ===== src/rlsd_pkg.sv =====
// ----------------------------------------------------------------------------
// Sprite cel decoder package
// Shared widths, codes and the command and status structures that join the
// controller to the datapath.
// ----------------------------------------------------------------------------
package rlsd_pkg;

  localparam int ADDR_W  = 24;
  localparam int POS_W   = ADDR_W + 2;
  localparam int LW_W    = 12;
  localparam int CNT_W   = 6;
  localparam int TDATA_W = ADDR_W + 8;
  localparam int CFG_W   = 24;
  localparam int IDX_W   = 3;

  localparam logic [IDX_W-1:0] REG_LINE_WIDTH    = 3'd0;
  localparam logic [IDX_W-1:0] REG_PIXEL_COUNT   = 3'd1;
  localparam logic [IDX_W-1:0] REG_KEY_COLOR     = 3'd2;
  localparam logic [IDX_W-1:0] REG_MIRROR_MODE   = 3'd3;
  localparam logic [IDX_W-1:0] REG_PACKED_FORMAT = 3'd4;

  localparam logic [1:0] PH_OPCODE  = 2'd0;
  localparam logic [1:0] PH_FILL    = 2'd1;
  localparam logic [1:0] PH_LITERAL = 2'd2;
  localparam logic [1:0] PH_DONE    = 2'd3;

  localparam logic [1:0] STATUS_PIXEL  = 2'd0;
  localparam logic [1:0] STATUS_MIDRUN = 2'd1;
  localparam logic [1:0] STATUS_SHORT  = 2'd2;

  localparam logic [7:0] OP_COUNT_MASK  = 8'h3f;
  localparam logic [7:0] OP_FILL_BIT    = 8'h80;
  localparam logic [7:0] OP_KEY_BIT     = 8'h40;
  localparam logic [7:0] OP_PACKED_MASK = 8'h07;

  typedef struct packed {
    logic load;
    logic decode;
    logic step;
    logic end_apply;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic phase_done;
    logic emit_more;
    logic step_hit;
    logic end_hit;
    logic busy_out;
    logic pend_valid;
  } stat_t;

endpackage

// ===== src/rle_sprite_cel_decoder_core.sv =====
// ----------------------------------------------------------------------------
// Run-length sprite cel decoder
// Expands encoded sprite bytes into indexed pixels with raster addresses.
// ----------------------------------------------------------------------------
// Each input transaction on the s_ channel carries one encoded byte, with the
// start of a cel flagged in s_tuser and the final available byte flagged on
// s_tlast. Each output transaction on the m_ channel carries one pixel
// (address and colour) or a status result; m_tlast marks the final result
// caused by an input byte. Registers are written through cfg_we, cfg_index
// and cfg_data, by the user only while idle; the block does not enforce it.
// One byte is taken at a time: a transaction passes decode, pixel steps,
// the end of data check and the flush. The single pixel position unit steps
// once a cycle over each position, clipped ones too, unless a new result is
// blocked at the output. A byte that arrives after the end of a cel is
// dropped in decode. The first pixel is formed by the first step and reaches
// the output with the next result or at the end of the transaction, because
// each result is held until the next one so that the final one can be marked.
// A stalled receiver holds the expansion only when a new result has nowhere
// to go; the block takes its next byte while the last result still waits.
// Synchronous reset restores the register defaults and the decoder state.
// ----------------------------------------------------------------------------
module rle_sprite_cel_decoder_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [7:0]                   s_tdata,   // data_byte
  input  logic [0:0]                   s_tuser,   // start_of_cel
  input  logic                         s_tlast,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [rlsd_pkg::TDATA_W-1:0] m_tdata,   // pixel_address, pixel_value
  output logic [1:0]                   m_tuser,   // status
  output logic                         m_tlast,
  input  logic                         cfg_we,
  input  logic [rlsd_pkg::IDX_W-1:0]   cfg_index,
  input  logic [rlsd_pkg::CFG_W-1:0]   cfg_data
);

  rlsd_pkg::cmd_t  cmd;
  rlsd_pkg::stat_t stat;

  rlsd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rlsd_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_byte   (s_tdata),
    .in_start  (s_tuser[0]),
    .in_end    (s_tlast),
    .cmd       (cmd),
    .stat      (stat),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

// ===== src/rlsd_ctrl.sv =====
// ----------------------------------------------------------------------------
// Sprite cel decoder controller
// Sequences one input transaction through decode, pixel expansion, the end
// of data check and the final flush of the held result.
// ----------------------------------------------------------------------------
module rlsd_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  rlsd_pkg::stat_t stat,
  output rlsd_pkg::cmd_t  cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DECODE = 3'd1;
  localparam logic [2:0] ST_EMIT   = 3'd2;
  localparam logic [2:0] ST_END    = 3'd3;
  localparam logic [2:0] ST_FLUSH  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (stat.phase_done) begin
          state_next = ST_IDLE;
        end else begin
          cmd.decode = 1'b1;
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!stat.emit_more) begin
          state_next = ST_END;
        end else if (!(stat.step_hit && stat.busy_out)) begin
          cmd.step = 1'b1;
        end
      end
      ST_END: begin
        if (!(stat.end_hit && stat.busy_out)) begin
          cmd.end_apply = 1'b1;
          state_next    = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!stat.busy_out) begin
          cmd.flush  = stat.pend_valid;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_load_only_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == ST_DECODE)
    else $error("load did not move to decode");
  a_flush_to_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FLUSH && !stat.busy_out) |=> in_ready)
    else $error("flush did not return to idle");
  a_step_not_blocked: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> !(stat.step_hit && stat.busy_out))
    else $error("step issued while the output is blocked");
`endif

endmodule

// ===== src/rlsd_dp.sv =====
// ----------------------------------------------------------------------------
// Sprite cel decoder datapath
// Configuration registers, decoder state, raster position arithmetic, the
// held result used to mark the final result and the output register.
// ----------------------------------------------------------------------------
module rlsd_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [rlsd_pkg::IDX_W-1:0]   cfg_index,
  input  logic [rlsd_pkg::CFG_W-1:0]   cfg_data,
  input  logic [7:0]                   in_byte,
  input  logic                         in_start,
  input  logic                         in_end,
  input  rlsd_pkg::cmd_t               cmd,
  output rlsd_pkg::stat_t              stat,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [rlsd_pkg::TDATA_W-1:0] m_tdata,
  output logic [1:0]                   m_tuser,
  output logic                         m_tlast
);

  localparam int POS_W = rlsd_pkg::POS_W;
  localparam int ADDR_W = rlsd_pkg::ADDR_W;
  localparam int CNT_W = rlsd_pkg::CNT_W;

  logic [rlsd_pkg::LW_W-1:0] line_width;
  logic [23:0]               pixel_count;
  logic [7:0]                key_color;
  logic                      mirror_mode;
  logic                      packed_format;

  logic [7:0]       byte_r;
  logic             end_r;
  logic [POS_W-1:0] wp;
  logic [POS_W-1:0] ls;
  logic [1:0]       phase;
  logic [CNT_W-1:0] run;
  logic             full;
  logic [CNT_W-1:0] cnt;
  logic [7:0]       color;

  logic              pend_valid;
  logic [ADDR_W-1:0] pend_addr;
  logic [7:0]        pend_value;
  logic [1:0]        pend_status;

  logic [rlsd_pkg::LW_W-1:0] eff_w;
  logic [POS_W-1:0] w_ext;
  logic [POS_W-1:0] pc_ext;
  logic [POS_W-1:0] ls_adv;
  logic [POS_W-1:0] wp_next;
  logic [POS_W-1:0] ls_next;
  logic             full_next;
  logic             step_hit;
  logic             end_hit;
  logic             new_result;
  logic             push;
  logic             flush_push;

  logic [CNT_W-1:0] dec_cnt;
  logic [7:0]       dec_color;
  logic [1:0]       dec_phase;
  logic [CNT_W-1:0] dec_run;

  assign eff_w  = (line_width == '0) ? {{(rlsd_pkg::LW_W-1){1'b0}}, 1'b1} : line_width;
  assign w_ext  = {{(POS_W-rlsd_pkg::LW_W){1'b0}}, eff_w};
  assign pc_ext = {{(POS_W-24){1'b0}}, pixel_count};

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width    <= {{(rlsd_pkg::LW_W-1){1'b0}}, 1'b1};
      pixel_count   <= 24'd1;
      key_color     <= 8'd0;
      mirror_mode   <= 1'b0;
      packed_format <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        rlsd_pkg::REG_LINE_WIDTH:    line_width    <= cfg_data[rlsd_pkg::LW_W-1:0];
        rlsd_pkg::REG_PIXEL_COUNT:   pixel_count   <= cfg_data[23:0];
        rlsd_pkg::REG_KEY_COLOR:     key_color     <= cfg_data[7:0];
        rlsd_pkg::REG_MIRROR_MODE:   mirror_mode   <= cfg_data[0];
        rlsd_pkg::REG_PACKED_FORMAT: packed_format <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    dec_cnt   = '0;
    dec_color = key_color;
    dec_phase = phase;
    dec_run   = run;
    if (!full) begin
      case (phase)
        rlsd_pkg::PH_OPCODE: begin
          if (packed_format) begin
            if ((byte_r & rlsd_pkg::OP_PACKED_MASK) != 8'd0) begin
              dec_cnt   = {3'b000, byte_r[2:0]};
              dec_color = {3'b000, byte_r[7:3]};
            end else begin
              dec_cnt = {1'b0, byte_r[7:3]};
            end
          end else if ((byte_r & rlsd_pkg::OP_FILL_BIT) != 8'd0) begin
            if ((byte_r & rlsd_pkg::OP_KEY_BIT) != 8'd0) begin
              dec_cnt = byte_r[CNT_W-1:0];
            end else begin
              dec_run   = byte_r[CNT_W-1:0];
              dec_phase = rlsd_pkg::PH_FILL;
            end
          end else if ((byte_r & rlsd_pkg::OP_COUNT_MASK) != 8'd0) begin
            dec_run   = byte_r[CNT_W-1:0];
            dec_phase = rlsd_pkg::PH_LITERAL;
          end
        end
        rlsd_pkg::PH_FILL: begin
          dec_cnt   = run;
          dec_color = byte_r;
          dec_run   = '0;
          dec_phase = rlsd_pkg::PH_OPCODE;
        end
        rlsd_pkg::PH_LITERAL: begin
          dec_cnt   = {{(CNT_W-1){1'b0}}, 1'b1};
          dec_color = byte_r;
          dec_run   = run - {{(CNT_W-1){1'b0}}, 1'b1};
          if (dec_run == '0) begin
            dec_phase = rlsd_pkg::PH_OPCODE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign ls_adv = ls + w_ext;

  always_comb begin
    if (mirror_mode) begin
      if (wp <= ls) begin
        ls_next = ls_adv;
        wp_next = ls_adv + w_ext - {{(POS_W-1){1'b0}}, 1'b1};
      end else begin
        ls_next = ls;
        wp_next = wp - {{(POS_W-1){1'b0}}, 1'b1};
      end
      full_next = ls_next >= pc_ext;
    end else begin
      ls_next   = ls;
      wp_next   = wp + {{(POS_W-1){1'b0}}, 1'b1};
      full_next = wp_next >= pc_ext;
    end
  end

  assign step_hit = wp < pc_ext;
  assign end_hit  = end_r && !full &&
                    (phase == rlsd_pkg::PH_FILL || phase == rlsd_pkg::PH_LITERAL ||
                     packed_format);

  assign new_result = (cmd.step && step_hit) || (cmd.end_apply && end_hit);
  assign push       = new_result && pend_valid;
  assign flush_push = cmd.flush && pend_valid;

  assign stat.phase_done = (phase == rlsd_pkg::PH_DONE);
  assign stat.emit_more  = (cnt != '0) && !full;
  assign stat.step_hit   = step_hit;
  assign stat.end_hit    = end_hit;
  assign stat.busy_out   = pend_valid && m_tvalid && !m_tready;
  assign stat.pend_valid = pend_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      ls    <= '0;
      phase <= rlsd_pkg::PH_OPCODE;
      run   <= '0;
      full  <= 1'b0;
      cnt   <= '0;
      end_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        end_r <= in_end;
        if (in_start) begin
          ls    <= '0;
          wp    <= mirror_mode ? (w_ext - {{(POS_W-1){1'b0}}, 1'b1}) : '0;
          phase <= rlsd_pkg::PH_OPCODE;
          run   <= '0;
          full  <= (pixel_count == 24'd0);
        end
      end
      if (cmd.decode) begin
        cnt   <= dec_cnt;
        phase <= dec_phase;
        run   <= dec_run;
      end
      if (cmd.step) begin
        wp   <= wp_next;
        ls   <= ls_next;
        full <= full_next;
        cnt  <= cnt - {{(CNT_W-1){1'b0}}, 1'b1};
      end
      if (cmd.end_apply && end_r) begin
        phase <= rlsd_pkg::PH_DONE;
        run   <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      byte_r <= in_byte;
    end
    if (cmd.decode) begin
      color <= dec_color;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (new_result) begin
      pend_valid <= 1'b1;
    end else if (flush_push) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && step_hit) begin
      pend_addr   <= wp[ADDR_W-1:0];
      pend_value  <= color;
      pend_status <= rlsd_pkg::STATUS_PIXEL;
    end else if (cmd.end_apply && end_hit) begin
      pend_addr   <= '0;
      pend_value  <= 8'd0;
      pend_status <= (phase == rlsd_pkg::PH_OPCODE) ? rlsd_pkg::STATUS_SHORT
                                                    : rlsd_pkg::STATUS_MIDRUN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (push || flush_push) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push || flush_push) begin
      m_tdata <= {pend_value, pend_addr};
      m_tuser <= pend_status;
      m_tlast <= flush_push;
    end
  end

`ifndef SYNTHESIS
  a_load_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> !pend_valid)
    else $error("a held result survived into the next transaction");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (push || flush_push) |-> (!m_tvalid || m_tready))
    else $error("output register overwritten while stalled");
  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != rlsd_pkg::STATUS_PIXEL) |-> (m_tdata == '0 && m_tlast))
    else $error("status result carries data or is not final");
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser != 2'd3))
    else $error("undefined status code on output");
  a_count_down: assert property (@(posedge clk) disable iff (rst)
    cmd.step |=> cnt == ($past(cnt) - {{(CNT_W-1){1'b0}}, 1'b1}))
    else $error("run counter did not step down");
`endif

endmodule
